// File: rtl/core/zste_pkg.sv
// Package for the zoomed sprite tile expander: status codes, register
// indexes, command and status structs shared by controller and datapath.
// No dependencies.
`default_nettype none
package zste_pkg;

   localparam logic [2:0] ST_TILE     = 3'd0;
   localparam logic [2:0] ST_LAST     = 3'd1;
   localparam logic [2:0] ST_ACCEPT   = 3'd2;
   localparam logic [2:0] ST_DISABLED = 3'd3;
   localparam logic [2:0] ST_ZERO     = 3'd4;
   localparam logic [2:0] ST_OFFCLIP  = 3'd5;
   localparam logic [2:0] ST_IDLE     = 3'd6;

   localparam logic [1:0] REG_CX0 = 2'd0;
   localparam logic [1:0] REG_CX1 = 2'd1;
   localparam logic [1:0] REG_CY0 = 2'd2;
   localparam logic [1:0] REG_CY1 = 2'd3;

   localparam int DIV_STEPS = 25;

   typedef struct packed {
      logic req_type;
      logic [15:0] attr;
      logic [15:0] page_offset;
      logic [15:0] color_page;
      logic [15:0] size;
      logic [15:0] pos_y;
      logic [15:0] pos_x;
      logic [15:0] zoom_y;
      logic [15:0] zoom_x;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [21:0] tile_code;
      logic [3:0]  palette;
      logic [1:0]  flips;
      logic [23:0] dest_x;
      logic [23:0] dest_y;
      logic [23:0] extent_x;
      logic [23:0] extent_y;
      logic [9:0]  box_x_low;
      logic [9:0]  box_x_high;
      logic [9:0]  box_y_low;
      logic [9:0]  box_y_high;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic check;     // decide draw bit and zero zoom
      logic div_start;
      logic div_step;
      logic setup;     // box, clip test, origin
      logic commit;    // store sprite state
      logic tile_mul;  // products for the tile
      logic tile_fin;  // form tile result, advance
      logic idle_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_step;
      logic reject;    // disabled or zero zoom
      logic off_clip;
      logic runnable;  // sprite pending with tiles
      logic div_done;
   } sts_type;

endpackage
`default_nettype wire

// File: rtl/core/zste_datapath.sv
// Datapath of the sprite tile expander: restoring divider, sprite setup,
// tile position multipliers and the result register. Uses zste_pkg.
`default_nettype none
module zste_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire zste_pkg::req_type_type req_data,
   input  wire zste_pkg::cmd_type    cmd,
   input  wire logic [9:0]           clip_x_low,
   input  wire logic [9:0]           clip_x_high,
   input  wire logic [9:0]           clip_y_low,
   input  wire logic [9:0]           clip_y_high,
   output zste_pkg::sts_type         sts,
   output zste_pkg::rsp_type         rsp_data
);
   import zste_pkg::*;

   req_type_type req_ff;
   rsp_type      rsp_ff, rsp_in;

   // sprite state
   logic        pend_ff, pend_in;
   logic [21:0] code_ff, code_in;
   logic [3:0]  pal_ff;
   logic [1:0]  flips_ff;
   logic signed [12:0] orgx_ff, orgy_ff;
   logic [24:0] rx_ff, ry_ff;
   logic [5:0]  cols_ff, rows_ff;
   logic [5:0]  col_ff, col_in, row_ff, row_in;
   logic [9:0]  box_ff [4];

   // divider: both quotients together, one bit a step
   logic [24:0] qx_ff, qy_ff, remx_ff, remy_ff;
   logic [4:0]  dcnt_ff;
   logic        ddone_ff;

   // setup results
   logic        offclip_ff;
   logic signed [12:0] sx_ff, sy_ff;
   logic [9:0]  b0_ff, b1_ff, b2_ff, b3_ff;
   logic [5:0]  xn_w, yn_w;

   // tile products
   logic signed [33:0] px0_ff, px1_ff, py0_ff, py1_ff;

   always_comb begin
      sts.is_step  = req_ff.req_type;
      sts.reject   = !req_ff.attr[2] || req_ff.zoom_x == 16'd0
                     || req_ff.zoom_y == 16'd0;
      sts.off_clip = offclip_ff;
      sts.runnable = pend_ff && cols_ff != 6'd0 && rows_ff != 6'd0;
      sts.div_done = ddone_ff;
   end

   logic [8:0] tx9, ty9, xs9, ys9;
   always_comb begin
      tx9 = {1'b0, req_ff.page_offset[7:0]};
      ty9 = {1'b0, req_ff.page_offset[15:8]};
      xs9 = {1'b0, req_ff.size[7:0]} + 9'd1;
      ys9 = {1'b0, req_ff.size[15:8]} + 9'd1;
      xn_w = 6'(((10'(tx9) + 10'(xs9) + 10'd7) >> 3) - 10'(tx9 >> 3));
      yn_w = 6'(((10'(ty9) + 10'(ys9) + 10'd7) >> 3) - 10'(ty9 >> 3));
   end

   // divider step
   logic [25:0] tx_r, ty_r;
   logic        bit_n;
   always_comb begin
      bit_n = (dcnt_ff == 5'd24);
      tx_r = {remx_ff, bit_n};
      ty_r = {remy_ff, bit_n};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (reset) begin
         ddone_ff <= 1'b0;
         dcnt_ff  <= '0;
      end else if (cmd.div_start) begin
         remx_ff <= '0; remy_ff <= '0; qx_ff <= '0; qy_ff <= '0;
         dcnt_ff <= 5'd24; ddone_ff <= 1'b0;
      end else if (cmd.div_step && !ddone_ff) begin
         // dividend 2^24: only bit 24 set
         if (tx_r >= {10'd0, req_ff.zoom_x}) begin
            remx_ff <= 25'(tx_r - {10'd0, req_ff.zoom_x});
            qx_ff <= {qx_ff[23:0], 1'b1};
         end else begin
            remx_ff <= tx_r[24:0];
            qx_ff <= {qx_ff[23:0], 1'b0};
         end
         if (ty_r >= {10'd0, req_ff.zoom_y}) begin
            remy_ff <= 25'(ty_r - {10'd0, req_ff.zoom_y});
            qy_ff <= {qy_ff[23:0], 1'b1};
         end else begin
            remy_ff <= ty_r[24:0];
            qy_ff <= {qy_ff[23:0], 1'b0};
         end
         if (dcnt_ff == 5'd0) ddone_ff <= 1'b1;
         else dcnt_ff <= dcnt_ff - 5'd1;
      end
   end

   // setup: box and clip
   logic signed [12:0] sxw, syw;
   logic signed [34:0] bx1w, by1w;
   logic signed [11:0] cx0, cx1, cy0, cy1;
   logic signed [34:0] b1c, b3c;
   logic signed [12:0] b0c, b2c;
   logic [33:0] mx, my;
   always_comb begin
      sxw = 13'(signed'({req_ff.pos_x[10], req_ff.pos_x[10:0]}));
      syw = 13'(signed'({req_ff.pos_y[9], req_ff.pos_y[9:0]}));
      mx = 34'(xs9) * 34'(qx_ff);
      my = 34'(ys9) * 34'(qy_ff);
      bx1w = 35'(sxw) + 35'(mx >> 16) - 35'sd1;
      by1w = 35'(syw) + 35'(my >> 16) - 35'sd1;
      cx0 = {2'b0, clip_x_low};  cx1 = {2'b0, clip_x_high};
      cy0 = {2'b0, clip_y_low};  cy1 = {2'b0, clip_y_high};
      b0c = (sxw < 13'(cx0)) ? 13'(cx0) : sxw;
      b1c = (bx1w > 35'(cx1)) ? 35'(cx1) : bx1w;
      b2c = (syw < 13'(cy0)) ? 13'(cy0) : syw;
      b3c = (by1w > 35'(cy1)) ? 35'(cy1) : by1w;
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         offclip_ff <= sxw > 13'(cx1) || bx1w < 35'(cx0)
                       || syw > 13'(cy1) || by1w < 35'(cy0);
         b0_ff <= b0c[9:0]; b1_ff <= b1c[9:0];
         b2_ff <= b2c[9:0]; b3_ff <= b3c[9:0];
         if (req_ff.attr[0])
            sx_ff <= sxw - 13'({xn_w, 3'b0}) + 13'(xs9) + 13'(tx9[2:0]);
         else
            sx_ff <= sxw - 13'(tx9[2:0]);
         if (req_ff.attr[1])
            sy_ff <= syw - 13'({yn_w, 3'b0}) + 13'(ys9) + 13'(ty9[2:0]);
         else
            sy_ff <= syw - 13'(ty9[2:0]);
      end
   end

   // tile index products: k * recip, scaled by 8 below, with k in -1..33
   logic fx, fy;
   logic signed [7:0] xi, yi, xi2, yi2;
   always_comb begin
      fx = flips_ff[0];
      fy = flips_ff[1];
      xi = fx ? 8'(cols_ff) - 8'sd1 - 8'(col_ff) : 8'(col_ff);
      yi = fy ? 8'(rows_ff) - 8'sd1 - 8'(row_ff) : 8'(row_ff);
      xi2 = fx ? xi - 8'sd1 : xi + 8'sd1;
      yi2 = fy ? yi - 8'sd1 : yi + 8'sd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.tile_mul) begin
         px0_ff <= 34'(xi) * signed'({9'd0, rx_ff});
         px1_ff <= 34'(xi2) * signed'({9'd0, rx_ff});
         py0_ff <= 34'(yi) * signed'({9'd0, ry_ff});
         py1_ff <= 34'(yi2) * signed'({9'd0, ry_ff});
      end
   end

   // arithmetic shift is floor for the signed sum
   logic signed [37:0] dx, ndx, dy, ndy, ex, ey;
   function automatic logic [23:0] sat24(input logic signed [37:0] v);
      if (v > 38'sd8388607) return 24'h7fffff;
      if (v < -38'sd8388608) return 24'h800000;
      return v[23:0];
   endfunction
   function automatic logic [23:0] abs24(input logic signed [37:0] v);
      logic signed [37:0] a;
      a = (v < 0) ? -v : v;
      if (a > 38'sd16777215) return 24'hffffff;
      return a[23:0];
   endfunction
   always_comb begin
      dx  = 38'(orgx_ff) + ((38'(px0_ff) * 38'sd8 + 38'sh8000) >>> 16);
      ndx = 38'(orgx_ff) + ((38'(px1_ff) * 38'sd8 + 38'sh8000) >>> 16);
      dy  = 38'(orgy_ff) + ((38'(py0_ff) * 38'sd8 + 38'sh8000) >>> 16);
      ndy = 38'(orgy_ff) + ((38'(py1_ff) * 38'sd8 + 38'sh8000) >>> 16);
      ex = ndx - dx;
      ey = ndy - dy;
   end

   logic last_col, last_row;
   always_comb begin
      last_col = (7'(col_ff) + 7'd1) >= 7'(cols_ff);
      last_row = (7'(row_ff) + 7'd1) >= 7'(rows_ff);
      rsp_in  = rsp_ff;
      pend_in = pend_ff;
      code_in = code_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (cmd.idle_rsp) begin
         rsp_in = '0;
         if (req_ff.req_type) begin
            rsp_in.status = ST_IDLE;
         end else if (!req_ff.attr[2]) begin
            rsp_in.status = ST_DISABLED;
         end else if (sts.reject) begin
            rsp_in.status = ST_ZERO;
         end else begin
            rsp_in.status = ST_OFFCLIP;
         end
         pend_in = 1'b0;
      end else if (cmd.commit) begin
         rsp_in = '0;
         rsp_in.status = ST_ACCEPT;
         rsp_in.box_x_low = b0_ff; rsp_in.box_x_high = b1_ff;
         rsp_in.box_y_low = b2_ff; rsp_in.box_y_high = b3_ff;
         pend_in = 1'b1;
         code_in = 22'({req_ff.page_offset[7:3]}) + 22'({req_ff.page_offset[15:11], 5'd0})
                   + 22'({req_ff.color_page[10:0], 10'd0});
         col_in = '0; row_in = '0;
      end else if (cmd.tile_fin) begin
         rsp_in.status = ST_TILE;
         rsp_in.tile_code = code_ff;
         rsp_in.palette = pal_ff;
         rsp_in.flips = flips_ff;
         rsp_in.dest_x = sat24(dx);
         rsp_in.dest_y = sat24(dy);
         rsp_in.extent_x = abs24(ex);
         rsp_in.extent_y = abs24(ey);
         rsp_in.box_x_low = box_ff[REG_CX0]; rsp_in.box_x_high = box_ff[REG_CX1];
         rsp_in.box_y_low = box_ff[REG_CY0]; rsp_in.box_y_high = box_ff[REG_CY1];
         code_in = code_ff + 22'd1;
         col_in = col_ff + 6'd1;
         if (last_col) begin
            col_in = '0;
            code_in = code_ff + 22'd33 - 22'(cols_ff);
            row_in = row_ff + 6'd1;
            if (last_row) begin
               row_in = '0;
               pend_in = 1'b0;
               rsp_in.status = ST_LAST;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.commit) begin
         pal_ff   <= req_ff.color_page[15:12];
         flips_ff <= req_ff.attr[1:0];
         orgx_ff  <= sx_ff;
         orgy_ff  <= sy_ff;
         rx_ff    <= qx_ff;
         ry_ff    <= qy_ff;
         cols_ff  <= xn_w;
         rows_ff  <= yn_w;
         box_ff[REG_CX0] <= b0_ff; box_ff[REG_CX1] <= b1_ff;
         box_ff[REG_CY0] <= b2_ff; box_ff[REG_CY1] <= b3_ff;
      end
      if (reset) begin
         pend_ff <= 1'b0;
         code_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         code_ff <= code_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/core/zste_ctrl.sv
// Controller state machine of the sprite tile expander: sequences load
// and step transactions over the datapath. Uses zste_pkg.
`default_nettype none
module zste_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire zste_pkg::sts_type sts,
   output zste_pkg::cmd_type    cmd
);
   import zste_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CHECK = 8'b0000_0010,
      S_DIV   = 8'b0000_0100,
      S_SETUP = 8'b0000_1000,
      S_DEC   = 8'b0001_0000,
      S_MUL   = 8'b0010_0000,
      S_FIN   = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      vld_ff, vld_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      vld_in = vld_ff;
      // a result may wait in the output register while the next request enters
      req_tready = (state_ff == S_IDLE);
      if (rsp_tvalid && rsp_tready) vld_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!vld_in) begin
               if (sts.is_step) begin
                  if (sts.runnable) state_in = S_MUL;
                  else begin
                     cmd.idle_rsp = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
                  end
               end else if (sts.reject) begin
                  cmd.idle_rsp = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            if (sts.off_clip) cmd.idle_rsp = 1'b1;
            else cmd.commit = 1'b1;
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         S_MUL: begin
            cmd.tile_mul = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.tile_fin = 1'b1;
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_tvalid = vld_ff;

endmodule
`default_nettype wire

// File: rtl/core/zoomed_sprite_tile_expander_unit.sv
// Top level of the zoomed sprite tile expander: clip registers, controller
// and datapath. Uses zste_pkg, zste_ctrl, zste_datapath.
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     tdata 128b, tuser req_type
//   rsp_     out  rsp_tvalid/tready     tdata 168b, tuser status
//   csr_     in   csr_valid/ready       csr_index 2b, csr_data 10b
//
// A step transaction passes through capture, decide, multiply and result.
// A load runs the 25-step reciprocal divider, which forms both reciprocals together.
// Reset is synchronous, clears control state and sets the clip window to 0..319 by 0..223.
// A held result in the output register stalls the next decision only.
`default_nettype none
module zoomed_sprite_tile_expander_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // attr, page_offset, color_page, size, pos_y, pos_x, zoom_y, zoom_x
   input  wire logic [127:0] req_tdata,
   // req_type
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tile_code, palette, flips, dest_x, dest_y, extent_x, extent_y,
   // box_x_low, box_x_high, box_y_low, box_y_high, zero fill
   output logic [167:0]      rsp_tdata,
   // status
   output logic [2:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [9:0]   csr_data
);
   import zste_pkg::*;

   logic [9:0] cx0_ff, cx1_ff, cy0_ff, cy1_ff;
   req_type_type req;
   rsp_type rsp;
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx0_ff <= 10'd0; cx1_ff <= 10'd319;
         cy0_ff <= 10'd0; cy1_ff <= 10'd223;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CX0: cx0_ff <= csr_data;
            REG_CX1: cx1_ff <= csr_data;
            REG_CY0: cy0_ff <= csr_data;
            REG_CY1: cy1_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      req.req_type    = req_tuser;
      req.attr        = req_tdata[15:0];
      req.page_offset = req_tdata[31:16];
      req.color_page  = req_tdata[47:32];
      req.size        = req_tdata[63:48];
      req.pos_y       = req_tdata[79:64];
      req.pos_x       = req_tdata[95:80];
      req.zoom_y      = req_tdata[111:96];
      req.zoom_x      = req_tdata[127:112];
   end

   zste_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .cmd(cmd)
   );

   zste_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req), .cmd(cmd),
      .clip_x_low(cx0_ff), .clip_x_high(cx1_ff),
      .clip_y_low(cy0_ff), .clip_y_high(cy1_ff),
      .sts(sts), .rsp_data(rsp)
   );

   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {4'b0000, rsp.box_y_high, rsp.box_y_low, rsp.box_x_high,
                       rsp.box_x_low, rsp.extent_y, rsp.extent_x, rsp.dest_y,
                       rsp.dest_x, rsp.flips, rsp.palette, rsp.tile_code};

`ifndef NO_ASSERTIONS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.commit, cmd.tile_fin, cmd.idle_rsp}))
      else $error("more than one result command");
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");
   a_result_rises: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit || cmd.tile_fin || cmd.idle_rsp) |=> rsp_tvalid)
      else $error("result not presented");
`endif

endmodule
`default_nettype wire

// File: dv/zste_checker.sv
// Checker for the zoomed sprite tile expander: watches the request, result
// and register channels, predicts each result and compares it field by field.
// Depends on zste_pkg.
module zste_checker
   import zste_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [127:0] req_tdata,
   input  wire logic         req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [167:0] rsp_tdata,
   input  wire logic [2:0]   rsp_tuser,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [9:0]   csr_data,
   output int                fail_count,
   output int                pending_count,
   output int                tiles_seen,
   output int                loads_seen
);

   rsp_type tile_cmd_queue[$];

   logic [9:0]  clip_win[4];
   logic        spr_live;
   logic [21:0] code_ctr;
   logic [3:0]  pal_hold;
   logic [1:0]  flip_hold;
   longint      org_x, org_y, rcp_x, rcp_y;
   int          n_cols, n_rows, col_at, row_at;
   logic [9:0]  box_hold[4];

   function automatic longint floor16(longint v);
      if (v >= 0) return v >>> 16;
      return -(((-v) - 1) >>> 16) - 1;
   endfunction

   function automatic longint zoomed_at(longint base, longint k, longint r);
      return base + floor16(k * r * 8 + 32768);
   endfunction

   function automatic logic [23:0] sat_pos(longint v);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[23:0];
   endfunction

   function automatic logic [23:0] span24(longint v);
      if (v < 0) v = -v;
      if (v > 64'hFFFFFF) v = 64'hFFFFFF;
      return v[23:0];
   endfunction

   task automatic predict_load(input logic [127:0] d, output rsp_type r);
      logic [15:0] attr, po, cp, sz, py, px, zy, zx;
      longint tx, ty, xs, ys, xn, yn, sx, sy, bx0, bx1, by0, by1, rx, ry;
      longint cx0, cx1, cy0, cy1;
      r = '0;
      {zx, zy, px, py, sz, cp, po, attr} = d;
      cx0 = clip_win[0]; cx1 = clip_win[1];
      cy0 = clip_win[2]; cy1 = clip_win[3];
      if (!attr[2]) begin
         spr_live = 0; r.status = ST_DISABLED; return;
      end
      if (zx == 0 || zy == 0) begin
         spr_live = 0; r.status = ST_ZERO; return;
      end
      rx = 64'h1000000 / zx;
      ry = 64'h1000000 / zy;
      tx = po[7:0]; ty = po[15:8];
      xs = sz[7:0] + 1; ys = sz[15:8] + 1;
      xn = ((tx + xs + 7) >>> 3) - (tx >>> 3);
      yn = ((ty + ys + 7) >>> 3) - (ty >>> 3);
      sx = longint'(px[9:0]) - (px[10] ? 1024 : 0);
      sy = longint'(py[8:0]) - (py[9] ? 512 : 0);
      bx0 = sx; bx1 = sx + ((xs * rx) >>> 16) - 1;
      by0 = sy; by1 = sy + ((ys * ry) >>> 16) - 1;
      if (bx0 > cx1 || bx1 < cx0 || by0 > cy1 || by1 < cy0) begin
         spr_live = 0; r.status = ST_OFFCLIP; return;
      end
      if (bx0 < cx0) bx0 = cx0;
      if (bx1 > cx1) bx1 = cx1;
      if (by0 < cy0) by0 = cy0;
      if (by1 > cy1) by1 = cy1;
      if (attr[0]) sx -= xn * 8 - xs - (tx & 7); else sx -= tx & 7;
      if (attr[1]) sy -= yn * 8 - ys - (ty & 7); else sy -= ty & 7;
      box_hold[0] = bx0[9:0]; box_hold[1] = bx1[9:0];
      box_hold[2] = by0[9:0]; box_hold[3] = by1[9:0];
      code_ctr = 22'((tx >>> 3) + (ty >>> 3) * 32 + longint'(cp[10:0]) * 1024);
      pal_hold = cp[15:12]; flip_hold = attr[1:0];
      org_x = sx; org_y = sy; rcp_x = rx; rcp_y = ry;
      n_cols = int'(xn); n_rows = int'(yn); col_at = 0; row_at = 0;
      spr_live = 1;
      r.status = ST_ACCEPT;
      r.box_x_low = box_hold[0]; r.box_x_high = box_hold[1];
      r.box_y_low = box_hold[2]; r.box_y_high = box_hold[3];
   endtask

   task automatic predict_tile(output rsp_type r);
      longint xi, yi, xinc, yinc, top, bot, dx, ndx;
      r = '0;
      if (!spr_live || n_cols == 0 || n_rows == 0) begin
         spr_live = 0; r.status = ST_IDLE; return;
      end
      xi = flip_hold[0] ? n_cols - 1 - col_at : col_at;
      yi = flip_hold[1] ? n_rows - 1 - row_at : row_at;
      xinc = flip_hold[0] ? -1 : 1;
      yinc = flip_hold[1] ? -1 : 1;
      top = zoomed_at(org_y, yi, rcp_y);
      bot = zoomed_at(org_y, yi + yinc, rcp_y);
      dx = zoomed_at(org_x, xi, rcp_x);
      ndx = zoomed_at(org_x, xi + xinc, rcp_x);
      r.tile_code = code_ctr; r.palette = pal_hold; r.flips = flip_hold;
      r.dest_x = sat_pos(dx); r.dest_y = sat_pos(top);
      r.extent_x = span24(ndx - dx); r.extent_y = span24(bot - top);
      r.box_x_low = box_hold[0]; r.box_x_high = box_hold[1];
      r.box_y_low = box_hold[2]; r.box_y_high = box_hold[3];
      code_ctr = code_ctr + 22'd1;
      col_at++;
      r.status = ST_TILE;
      if (col_at >= n_cols) begin
         col_at = 0;
         code_ctr = code_ctr + 22'(32 - n_cols);
         row_at++;
         if (row_at >= n_rows) begin
            row_at = 0; spr_live = 0; r.status = ST_LAST;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want, got;
      if (reset) begin
         clip_win[0] <= 10'd0; clip_win[1] <= 10'd319;
         clip_win[2] <= 10'd0; clip_win[3] <= 10'd223;
         spr_live = 0; code_ctr = 0; pal_hold = 0; flip_hold = 0;
         org_x = 0; org_y = 0; rcp_x = 0; rcp_y = 0;
         n_cols = 0; n_rows = 0; col_at = 0; row_at = 0;
         for (int i = 0; i < 4; i++) box_hold[i] = 0;
         fail_count = 0; tiles_seen = 0; loads_seen = 0;
      end else begin
         if (csr_valid && csr_ready) clip_win[csr_index] <= csr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               predict_tile(want); tiles_seen++;
            end else begin
               predict_load(req_tdata, want); loads_seen++;
            end
            tile_cmd_queue.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status     = rsp_tuser;
            got.tile_code  = rsp_tdata[21:0];
            got.palette    = rsp_tdata[25:22];
            got.flips      = rsp_tdata[27:26];
            got.dest_x     = rsp_tdata[51:28];
            got.dest_y     = rsp_tdata[75:52];
            got.extent_x   = rsp_tdata[99:76];
            got.extent_y   = rsp_tdata[123:100];
            got.box_x_low  = rsp_tdata[133:124];
            got.box_x_high = rsp_tdata[143:134];
            got.box_y_low  = rsp_tdata[153:144];
            got.box_y_high = rsp_tdata[163:154];
            if (tile_cmd_queue.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_tuser, 0);
            end else begin
               want = tile_cmd_queue.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.tile_code != want.tile_code)
                  report_mismatch("tile_code", got.tile_code, want.tile_code);
               if (got.palette != want.palette)
                  report_mismatch("palette", got.palette, want.palette);
               if (got.flips != want.flips)
                  report_mismatch("flips", got.flips, want.flips);
               if (got.dest_x != want.dest_x)
                  report_mismatch("dest_x", got.dest_x, want.dest_x);
               if (got.dest_y != want.dest_y)
                  report_mismatch("dest_y", got.dest_y, want.dest_y);
               if (got.extent_x != want.extent_x)
                  report_mismatch("extent_x", got.extent_x, want.extent_x);
               if (got.extent_y != want.extent_y)
                  report_mismatch("extent_y", got.extent_y, want.extent_y);
               if (got.box_x_low != want.box_x_low)
                  report_mismatch("box_x_low", got.box_x_low, want.box_x_low);
               if (got.box_x_high != want.box_x_high)
                  report_mismatch("box_x_high", got.box_x_high, want.box_x_high);
               if (got.box_y_low != want.box_y_low)
                  report_mismatch("box_y_low", got.box_y_low, want.box_y_low);
               if (got.box_y_high != want.box_y_high)
                  report_mismatch("box_y_high", got.box_y_high, want.box_y_high);
               if (rsp_tdata[167:164] != 4'b0000)
                  report_mismatch("zero fill", rsp_tdata[167:164], 0);
            end
         end
      end
      pending_count = tile_cmd_queue.size();
   end

endmodule

// File: dv/testbench.sv
// Top of the sprite tile expander testbench: clock, reset, stimulus on the
// request and register channels, result back-pressure and the verdict.
// Depends on zste_pkg, zste_checker and zoomed_sprite_tile_expander_unit.
module testbench;
   import zste_pkg::*;

   logic         clock, reset;
   logic         req_tvalid, req_tready, req_tuser;
   logic [127:0] req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [167:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_valid, csr_ready;
   logic [1:0]   csr_index;
   logic [9:0]   csr_data;
   int           fail_count, pending_count, tiles_seen, loads_seen;
   int           cycle_count;
   bit           no_idle, hold_off;

   zoomed_sprite_tile_expander_unit u_top (.*);

   zste_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 1500000) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         rsp_tready <= no_idle || ($urandom_range(99) >= 27);
      end
   end

   // the block drops ready after each transaction it takes,
   // so the extra falling edge at the end costs nothing
   task automatic send_item(input bit step, input logic [127:0] d);
      while (!no_idle && $urandom_range(99) < 27) @(negedge clock);
      req_tvalid <= 1; req_tuser <= step; req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid <= 0;
      @(negedge clock);
   endtask

   task automatic drain;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_clip(input logic [1:0] idx, input logic [9:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   function automatic logic [127:0] pack_sprite(
      logic [15:0] attr, po, cp, sz, py, px, zy, zx);
      return {zx, zy, px, py, sz, cp, po, attr};
   endfunction

   function automatic logic [15:0] pick_zoom();
      case ($urandom_range(5))
         0: return 16'($urandom_range(1, 16));
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(32'h2000, 32'h4000));
      endcase
   endfunction

   function automatic logic [127:0] random_sprite();
      logic [15:0] attr, sz;
      attr = 16'($urandom);
      if ($urandom_range(9) != 0) attr[2] = 1;
      sz = $urandom_range(3) == 0 ? 16'($urandom) :
           {8'($urandom_range(23)), 8'($urandom_range(23))};
      return pack_sprite(attr, 16'($urandom), 16'($urandom), sz,
                         16'($urandom) & ($urandom_range(1) ? 16'hFFFF : 16'h00FF),
                         16'($urandom) & ($urandom_range(1) ? 16'hFFFF : 16'h00FF),
                         $urandom_range(19) == 0 ? 16'd0 : pick_zoom(),
                         $urandom_range(19) == 0 ? 16'd0 : pick_zoom());
   endfunction

   task automatic run_sprite(input logic [127:0] d, input int extra);
      int n;
      send_item(0, d);
      n = (((d[23:16] + d[55:48] + 8) >> 3) - (d[23:16] >> 3)) *
          (((d[31:24] + d[63:56] + 8) >> 3) - (d[31:24] >> 3));
      if (n > 40) n = 40;
      repeat (n + extra) send_item(1, 128'($urandom) << $urandom_range(96));
   endtask

   task automatic random_phase(input int items);
      int base;
      base = loads_seen + tiles_seen;
      while (loads_seen + tiles_seen - base < items) begin
         if ($urandom_range(9) == 0) begin
            send_item($urandom_range(1), {$urandom, $urandom, $urandom, $urandom});
         end else begin
            run_sprite(random_sprite(), $urandom_range(3) == 0 ? 1 : 0);
         end
      end
   endtask

   initial begin
      req_tvalid = 0; req_tuser = 0; req_tdata = '0;
      csr_valid = 0; csr_index = REG_CX0; csr_data = '0;
      no_idle = 0; hold_off = 0;
      reset = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: idle step, rejections, flips, wide and tiny zooms
      send_item(1, '0);
      send_item(0, pack_sprite(16'h0003, 0, 0, 0, 0, 0, 16'h4000, 16'h4000));
      send_item(0, pack_sprite(16'h0004, 0, 0, 0, 0, 0, 16'h0000, 16'h4000));
      send_item(0, pack_sprite(16'h0004, 0, 0, 0, 0, 0, 16'h4000, 16'h0000));
      send_item(0, pack_sprite(16'h0004, 0, 0, 0, 16'h01FF, 16'h03FF, 16'h4000, 16'h4000));
      run_sprite(pack_sprite(16'h0004, 16'h0305, 16'hF7FF, 16'h0907, 16'h0010,
                             16'h0020, 16'h4000, 16'h4000), 1);
      run_sprite(pack_sprite(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0101, 16'hFFF0,
                             16'hFFF0, 16'h2000, 16'h6000), 0);
      run_sprite(pack_sprite(16'h0006, 16'h0000, 16'h1000, 16'h0000, 0, 0,
                             16'h0001, 16'h0001), 0);
      run_sprite(pack_sprite(16'h0005, 16'h0000, 16'h2000, 16'h0000, 0, 0,
                             16'hFFFF, 16'hFFFF), 0);
      send_item(0, pack_sprite(16'h0004, 0, 0, 16'h0707, 0, 0, 16'h4000, 16'h4000));
      send_item(0, pack_sprite(16'h0005, 0, 16'h3000, 16'h0707, 0, 0, 16'h4000, 16'h4000));
      send_item(1, '0);
      drain();

      // inverted and extreme windows
      write_clip(REG_CX0, 10'd1023); write_clip(REG_CX1, 10'd0);
      write_clip(REG_CY0, 10'd1023); write_clip(REG_CY1, 10'd0);
      random_phase(40);
      drain();
      write_clip(REG_CX0, 10'd0); write_clip(REG_CX1, 10'd1023);
      write_clip(REG_CY0, 10'd0); write_clip(REG_CY1, 10'd1023);
      no_idle = 1;
      random_phase(150);
      no_idle = 0;
      drain();

      // stall the result side while requests keep coming
      hold_off = 1;
      random_phase(60);
      drain();
      write_clip(REG_CX0, 10'($urandom)); write_clip(REG_CX1, 10'($urandom));
      write_clip(REG_CY0, 10'($urandom)); write_clip(REG_CY1, 10'($urandom));
      random_phase(100);
      drain();
      write_clip(REG_CX0, 10'd0); write_clip(REG_CX1, 10'd319);
      write_clip(REG_CY0, 10'd0); write_clip(REG_CY1, 10'd223);
      random_phase(200);
      drain();

      $display("Covered %0d sprite loads and %0d tile steps over four clip windows.",
               loads_seen, tiles_seen);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
